// ----- rtl/ftn_pkg.sv -----
`default_nettype none
// ============================================================================
// ftn_pkg: shared types and constants for the frequency table
// Field widths, status codes and the cell control word.
// ============================================================================
package ftn_pkg;

    localparam int ID_BITS             = 31;
    localparam int OCC_BITS            = 16;
    localparam int STATUS_BITS         = 2;
    localparam int TOPN_BITS           = 5;
    localparam int MAX_RESULTS         = 16;
    localparam int TABLE_ENTRIES_DEF   = 16;
    localparam int COUNT_BITS_DEF      = 16;

    localparam logic [STATUS_BITS-1:0] STATUS_RECORDED = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_DROPPED  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_RANKED   = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_NONE     = 2'd3;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     is_new;   // insert of a new id rather than a moved entry
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/ftn_cell.sv -----
`default_nettype none
// ============================================================================
// ftn_cell: one table slot of the sorted chain
// Holds one id and its count; takes a new entry, its upper neighbor or its
// lower neighbor as told.
// ============================================================================
module ftn_cell #(
    parameter int COUNT_BITS = ftn_pkg::COUNT_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ftn_pkg::cell_ctrl_t          ctrl,
    input  wire logic [ftn_pkg::ID_BITS-1:0]  find_id,
    input  wire logic [COUNT_BITS-1:0]        new_count,
    input  wire logic [COUNT_BITS-1:0]        old_count,
    input  wire logic                         up_valid,
    input  wire logic [ftn_pkg::ID_BITS-1:0]  up_id,
    input  wire logic [COUNT_BITS-1:0]        up_count,
    input  wire logic                         up_lt,
    input  wire logic                         dn_valid,
    input  wire logic [ftn_pkg::ID_BITS-1:0]  dn_id,
    input  wire logic [COUNT_BITS-1:0]        dn_count,
    output logic                              valid,
    output logic [ftn_pkg::ID_BITS-1:0]       id,
    output logic [COUNT_BITS-1:0]             count,
    output logic                              match,
    output logic                              lt
);
    import ftn_pkg::*;

    logic                  valid_reg, valid_next;
    logic [ID_BITS-1:0]    id_reg, id_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  ge_old;
    logic                  in_range;

    // key order: count first, then id
    assign lt     = !valid_reg || (count_reg < new_count) ||
                    ((count_reg == new_count) && (id_reg < find_id));
    assign ge_old = (count_reg > old_count) ||
                    ((count_reg == old_count) && (id_reg >= find_id));
    assign in_range = ctrl.is_new ? (valid_reg || up_valid) : (valid_reg && ge_old);
    assign match  = valid_reg && (id_reg == find_id);

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        count_next = count_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (in_range && lt)
                begin
                    if (up_lt)
                    begin
                        valid_next = up_valid;
                        id_next    = up_id;
                        count_next = up_count;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        id_next    = find_id;
                        count_next = new_count;
                    end
                end
            end
            CELL_ROTATE:
            begin
                valid_next = dn_valid;
                id_next    = dn_id;
                count_next = dn_count;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        count_reg <= count_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign count = count_reg;

endmodule
`default_nettype wire

// ----- rtl/frequency_table_top_n_core.sv -----
`default_nettype none
// ============================================================================
// frequency_table_top_n_core: id frequency table with top-N query
// Record: the id is compared in FIND, then the result word is registered in MOVE.
// Query: results are read from cell 0 during one full rotation of the cell
// chain; an empty answer is a single word.
// Output stalls hold the sequencer. Reset empties the table at once.
// ============================================================================
module frequency_table_top_n_core #(
    parameter int TABLE_ENTRIES = ftn_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = ftn_pkg::COUNT_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             command,
    input  wire logic [ftn_pkg::ID_BITS-1:0]      item_id,
    input  wire logic [ftn_pkg::TOPN_BITS-1:0]    top_n,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [ftn_pkg::STATUS_BITS-1:0]       status,
    output logic [ftn_pkg::ID_BITS-1:0]           ranked_id,
    output logic [ftn_pkg::OCC_BITS-1:0]          occurrences,
    output logic                                  last
);
    import ftn_pkg::*;

    // The table is a chain of cells kept sorted at all times: cell 0 holds the
    // highest count (larger id first on ties). A record compares all cells to
    // the id (FIND), then (MOVE) the updated entry is lifted to
    // its place while the cells it passes each step down by one neighbor.
    // A query rotates the chain toward cell 0 once around, reading cell 0.

    localparam int UW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_MOVE,
        S_QUERY
    } state_t;

    state_t                  state_reg, state_next;
    logic [ID_BITS-1:0]      id_reg, id_next;
    logic [UW-1:0]           used_reg, used_next;
    logic [UW-1:0]           n_reg, n_next;
    logic [UW-1:0]           step_reg, step_next;
    logic                    match_any_reg, match_any_next;
    logic [COUNT_BITS-1:0]   old_count_reg, old_count_next;
    logic [COUNT_BITS-1:0]   new_count_reg, new_count_next;

    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0]  status_reg, status_next;
    logic [ID_BITS-1:0]      ranked_id_reg, ranked_id_next;
    logic [OCC_BITS-1:0]     occ_reg, occ_next;
    logic                    last_reg, last_next;

    cell_ctrl_t              ctrl;
    logic                    slot_free;
    logic                    match_any;
    logic [COUNT_BITS-1:0]   match_count;
    logic [COUNT_BITS-1:0]   occ_src;
    logic [OCC_BITS-1:0]     occ_sat;
    logic [31:0]             n_wide;

    logic                    cell_valid [TABLE_ENTRIES];
    logic [ID_BITS-1:0]      cell_id    [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0]   cell_count [TABLE_ENTRIES];
    logic                    cell_match [TABLE_ENTRIES];
    logic                    cell_lt    [TABLE_ENTRIES];

    // ---- cell chain ---------------------------------------------------------
    for (genvar j = 0; j < TABLE_ENTRIES; j++)
    begin : g_cell
        localparam int DN = (j + 1) % TABLE_ENTRIES;
        localparam int UP = (j == 0) ? 0 : j - 1;
        logic up_valid_w;
        logic up_lt_w;

        // cell 0 has nothing above it: in range for a new id, never shifts down
        assign up_valid_w = (j == 0) ? 1'b1 : cell_valid[UP];
        assign up_lt_w    = (j == 0) ? 1'b0 : cell_lt[UP];

        ftn_cell #(
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .find_id   (id_reg),
            .new_count (new_count_reg),
            .old_count (old_count_reg),
            .up_valid  (up_valid_w),
            .up_id     (cell_id[UP]),
            .up_count  (cell_count[UP]),
            .up_lt     (up_lt_w),
            .dn_valid  (cell_valid[DN]),
            .dn_id     (cell_id[DN]),
            .dn_count  (cell_count[DN]),
            .valid     (cell_valid[j]),
            .id        (cell_id[j]),
            .count     (cell_count[j]),
            .match     (cell_match[j]),
            .lt        (cell_lt[j])
        );
    end

    // at most one cell matches, so an OR gathers its count
    always_comb
    begin
        match_any   = 1'b0;
        match_count = '0;
        for (int j = 0; j < TABLE_ENTRIES; j++)
        begin
            match_any   = match_any | cell_match[j];
            match_count = match_count | (cell_match[j] ? cell_count[j] : '0);
        end
    end

    // ---- occurrence saturation to the output width -------------------------
    assign occ_src = (state_reg == S_QUERY) ? cell_count[0] : new_count_reg;

    if (COUNT_BITS > OCC_BITS)
    begin : g_sat
        assign occ_sat = (occ_src > COUNT_BITS'({OCC_BITS{1'b1}})) ?
                         {OCC_BITS{1'b1}} : occ_src[OCC_BITS-1:0];
    end
    else
    begin : g_ext
        assign occ_sat = OCC_BITS'(occ_src);
    end

    // query length: min(top_n, used, MAX_RESULTS)
    always_comb
    begin
        n_wide = (32'(top_n) < 32'(used_reg)) ? 32'(top_n) : 32'(used_reg);
        if (n_wide > 32'(MAX_RESULTS))
            n_wide = 32'(MAX_RESULTS);
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);

    // ---- sequencer ----------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        id_next        = id_reg;
        used_next      = used_reg;
        n_next         = n_reg;
        step_next      = step_reg;
        match_any_next = match_any_reg;
        old_count_next = old_count_reg;
        new_count_next = new_count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        ranked_id_next = ranked_id_reg;
        occ_next       = occ_reg;
        last_next      = last_reg;
        ctrl.op        = CELL_HOLD;
        ctrl.is_new    = !match_any_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    id_next   = item_id;
                    n_next    = UW'(n_wide);
                    step_next = '0;
                    state_next = (command == CMD_QUERY) ? S_QUERY : S_FIND;
                end
            end
            S_FIND:
            begin
                match_any_next = match_any;
                old_count_next = match_count;
                if (!match_any)
                    new_count_next = COUNT_BITS'(1);
                else if (match_count == COUNT_MAX)
                    new_count_next = match_count;
                else
                    new_count_next = match_count + COUNT_BITS'(1);
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    ranked_id_next = id_reg;
                    last_next      = 1'b1;
                    if (!match_any_reg && (used_reg == UW'(TABLE_ENTRIES)))
                    begin
                        // table full, new id dropped
                        status_next = STATUS_DROPPED;
                        occ_next    = '0;
                    end
                    else
                    begin
                        ctrl.op     = CELL_INSERT;
                        status_next = STATUS_RECORDED;
                        occ_next    = occ_sat;
                        if (!match_any_reg)
                            used_next = used_reg + UW'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            S_QUERY:
            begin
                if (n_reg == '0)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = STATUS_NONE;
                        ranked_id_next = '0;
                        occ_next       = '0;
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if ((step_reg >= n_reg) || slot_free)
                begin
                    if (step_reg < n_reg)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = STATUS_RANKED;
                        ranked_id_next = cell_id[0];
                        occ_next       = occ_sat;
                        last_next      = (step_reg == n_reg - UW'(1));
                    end
                    // one full turn leaves the chain in its sorted order
                    ctrl.op   = CELL_ROTATE;
                    step_next = step_reg + UW'(1);
                    if (step_reg == UW'(TABLE_ENTRIES - 1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        n_reg         <= n_next;
        step_reg      <= step_next;
        match_any_reg <= match_any_next;
        old_count_reg <= old_count_next;
        new_count_reg <= new_count_next;
        status_reg    <= status_next;
        ranked_id_reg <= ranked_id_next;
        occ_reg       <= occ_next;
        last_reg      <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign ranked_id   = ranked_id_reg;
    assign occurrences = occ_reg;
    assign last        = last_reg;

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb: testbench for frequency_table_top_n_core
// Sends record and query words over the input handshake. A scoreboard class
// keeps its own copy of the id table and predicts each result word. Every
// result word is checked field by field, in order, under several idle and
// stall mixes. A recurring id pool fills the table so drops are covered.
// ============================================================================

module tb;
    import ftn_pkg::*;

    localparam int POOL_SIZE      = 24;     // recurring ids, more than the table holds
    localparam int PHASE_WORDS    = 80;     // random words per idle phase
    localparam int DRAIN_CYCLES   = 4 * (TABLE_ENTRIES_DEF + 1);

    // One result word as the block should emit it.
    typedef struct packed {
        logic [STATUS_BITS-1:0] st;
        logic [ID_BITS-1:0]     id;
        logic [OCC_BITS-1:0]    occ;
        logic                   lst;
    } result_word_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the table, queue of predicted result words.
    // ------------------------------------------------------------------------
    class ranking_board;
        logic [ID_BITS-1:0]  held_ids    [TABLE_ENTRIES_DEF];
        logic [OCC_BITS-1:0] held_counts [TABLE_ENTRIES_DEF];
        int unsigned         held_used;
        result_word_t        pending_words [$];
        int unsigned         errors;
        int unsigned         words_in;
        int unsigned         words_checked;
        int unsigned         dropped;
        int unsigned         ranked;
        int unsigned         saturated;

        function new();
            held_used     = 0;
            errors        = 0;
            words_in      = 0;
            words_checked = 0;
            dropped       = 0;
            ranked        = 0;
            saturated     = 0;
        endfunction

        function void push_word(logic [STATUS_BITS-1:0] st, logic [ID_BITS-1:0] id,
                                logic [OCC_BITS-1:0] occ, logic lst);
            result_word_t w;
            w.st  = st;
            w.id  = id;
            w.occ = occ;
            w.lst = lst;
            pending_words.insert(pending_words.size(), w);
        endfunction

        function void predict_record(logic [ID_BITS-1:0] id);
            for (int unsigned i = 0; i < held_used; i++) begin
                if (held_ids[i] == id) begin
                    if (held_counts[i] != '1)
                        held_counts[i]++;
                    else
                        saturated++;
                    push_word(STATUS_RECORDED, id, held_counts[i], 1'b1);
                    return;
                end
            end
            if (held_used >= TABLE_ENTRIES_DEF) begin
                dropped++;
                push_word(STATUS_DROPPED, id, '0, 1'b1);
                return;
            end
            held_ids[held_used]    = id;
            held_counts[held_used] = OCC_BITS'(1);
            held_used++;
            push_word(STATUS_RECORDED, id, OCC_BITS'(1), 1'b1);
        endfunction

        // Selection sort over the used entries: higher count first, larger id on ties.
        function void predict_query(logic [TOPN_BITS-1:0] wanted);
            int unsigned n;
            int unsigned best;
            bit          have;
            bit          taken [TABLE_ENTRIES_DEF];
            n = wanted;
            if (n > held_used)   n = held_used;
            if (n > MAX_RESULTS) n = MAX_RESULTS;
            if (n == 0) begin
                push_word(STATUS_NONE, '0, '0, 1'b1);
                return;
            end
            foreach (taken[i]) taken[i] = 1'b0;
            for (int unsigned k = 0; k < n; k++) begin
                best = 0;
                have = 1'b0;
                for (int unsigned i = 0; i < held_used; i++) begin
                    if (taken[i]) continue;
                    if (!have || held_counts[i] > held_counts[best] ||
                        (held_counts[i] == held_counts[best] &&
                         held_ids[i] > held_ids[best])) begin
                        best = i;
                        have = 1'b1;
                    end
                end
                taken[best] = 1'b1;
                ranked++;
                push_word(STATUS_RANKED, held_ids[best], held_counts[best], k + 1 == n);
            end
        endfunction

        function void note_command(logic cmd, logic [ID_BITS-1:0] id,
                                   logic [TOPN_BITS-1:0] wanted);
            words_in++;
            if (cmd == CMD_RECORD)
                predict_record(id);
            else
                predict_query(wanted);
        endfunction

        function void check_word(logic [STATUS_BITS-1:0] st, logic [ID_BITS-1:0] id,
                                 logic [OCC_BITS-1:0] occ, logic lst);
            result_word_t w;
            words_checked++;
            if (pending_words.size() == 0) begin
                $error("unexpected result word: status %0d id %0h occurrences %0d last %0b",
                       st, id, occ, lst);
                errors++;
                return;
            end
            w = pending_words.pop_front();
            if (st !== w.st) begin
                $error("status: expected %0d, actual %0d", w.st, st);
                errors++;
            end
            if (id !== w.id) begin
                $error("ranked_id: expected %0h, actual %0h", w.id, id);
                errors++;
            end
            if (occ !== w.occ) begin
                $error("occurrences: expected %0d, actual %0d", w.occ, occ);
                errors++;
            end
            if (lst !== w.lst) begin
                $error("last: expected %0b, actual %0b", w.lst, lst);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_words.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block signals. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic                   command   = CMD_RECORD;
    logic [ID_BITS-1:0]     item_id   = '0;
    logic [TOPN_BITS-1:0]   top_n     = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [STATUS_BITS-1:0] status;
    logic [ID_BITS-1:0]     ranked_id;
    logic [OCC_BITS-1:0]    occurrences;
    logic                   last;

    ranking_board board = new();

    // Idle mix of the current phase, in percent of cycles.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    logic [ID_BITS-1:0] id_pool [POOL_SIZE];

    frequency_table_top_n_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .item_id     (item_id),
        .top_n       (top_n),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .ranked_id   (ranked_id),
        .occurrences (occurrences),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver: stall at random per cycle, as the phase asks.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result monitor: values seen here are the ones from before this edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_word(status, ranked_id, occurrences, last);
    end

    // ------------------------------------------------------------------------
    // Sender: optional idle cycles, then hold the word until accepted.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic cmd, input logic [ID_BITS-1:0] id,
                             input logic [TOPN_BITS-1:0] wanted);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        item_id  <= id;
        top_n    <= wanted;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_command(cmd, id, wanted);
    endtask

    // Mostly records from a recurring pool so counts grow and the table fills;
    // some fresh ids, and queries of all lengths. Ignored fields carry noise.
    task automatic random_word();
        int unsigned          pick;
        logic [ID_BITS-1:0]   id;
        logic [TOPN_BITS-1:0] wanted;
        pick   = $urandom_range(0, 99);
        id     = ID_BITS'($urandom);
        wanted = TOPN_BITS'($urandom);
        if (pick < 60) begin
            send_word(CMD_RECORD, id_pool[$urandom_range(0, POOL_SIZE - 1)], wanted);
        end
        else if (pick < 68) begin
            send_word(CMD_RECORD, id, wanted);
        end
        else begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                wanted = '0;
            else if (pick < 8)
                wanted = TOPN_BITS'($urandom_range(1, MAX_RESULTS));
            send_word(CMD_QUERY, id, wanted);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned phase_send  [4];
        int unsigned phase_stall [4];
        phase_send  = '{0, 63, 0, 24};
        phase_stall = '{0, 0, 63, 24};

        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = ID_BITS'($urandom);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty table, extreme ids, zero and oversize top_n, ties.
        send_word(CMD_QUERY,  '1,            TOPN_BITS'(16));   // empty table
        send_word(CMD_QUERY,  '0,            '0);               // empty, zero asked
        send_word(CMD_RECORD, '0,            '1);
        send_word(CMD_RECORD, '1,            '0);
        send_word(CMD_RECORD, '1,            '0);
        send_word(CMD_RECORD, 31'h2AAA_AAAA, TOPN_BITS'(5'h0A));
        send_word(CMD_RECORD, 31'h5555_5555, TOPN_BITS'(5'h15));
        send_word(CMD_QUERY,  '0,            '0);               // zero asked, table held
        send_word(CMD_QUERY,  '0,            TOPN_BITS'(1));
        send_word(CMD_QUERY,  '1,            '1);               // more than held
        send_word(CMD_RECORD, 31'h5555_5555, '0);               // tie at count 2
        send_word(CMD_QUERY,  '0,            TOPN_BITS'(16));
        send_word(CMD_QUERY,  '0,            TOPN_BITS'(3));

        // Random words under each idle mix; the table fills, then drops begin.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_stall[p];
            repeat (PHASE_WORDS) random_word();
        end

        // Full ranking of the final table, then one more record on it.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_word(CMD_QUERY,  '0, TOPN_BITS'(16));
        send_word(CMD_RECORD, '1, '0);
        in_valid <= 1'b0;

        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d input words and %0d result words (%0d ranked, %0d dropped)",
                 board.words_in, board.words_checked, board.ranked, board.dropped);
        $display("records at the count ceiling: %0d; table entries in use: %0d",
                 board.saturated, board.held_used);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
